/* rtl/bitmap_block_allocator_assert.svh */
// assertion macros for the bitmap block allocator
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

// condition must hold in the same cycle, checked out of reset
`define BBA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bitmap block allocator check failed");

// condition must hold in the next cycle, checked out of reset
`define BBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bitmap block allocator check failed");

`endif

/* rtl/bba_pkg.sv */
// shared types, constants and helpers for the bitmap block allocator
package bba_pkg;

  // fixed field widths
  localparam int InodeW   = 12;
  localparam int MapCntW  = 3;
  localparam int OpcodeW  = 2;
  localparam int BlockW   = 16;
  localparam int ByteIdxW = 11;
  localparam int ByteW    = 8;
  localparam int StatusW  = 2;

  // byte constants
  localparam logic [ByteW-1:0] ByteMsb = 8'h80;
  localparam logic [ByteW-1:0] ByteAll = 8'hFF;

  // configuration register indexes
  localparam logic CfgInodeCount = 1'b0;
  localparam logic CfgMapBlocks  = 1'b1;

  typedef enum logic [OpcodeW-1:0] {
    OpAlloc   = 2'd0,
    OpFree    = 2'd1,
    OpPreload = 2'd2
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    StOk      = 2'd0,
    StNoSpace = 2'd1,
    StRange   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    SClear,
    SIdle,
    SScan,
    SFreeWr,
    SResp
  } state_e;

  typedef struct packed {
    logic       found;
    logic [2:0] pos;
  } clear_pos_t;

  // first clear bit of a map byte, msb is position 0
  function automatic clear_pos_t first_clear(input logic [ByteW-1:0] map_byte);
    clear_pos_t res;
    res = '0;
    for (int b = 7; b >= 0; b--) begin
      if (!map_byte[7-b]) begin
        res.found = 1'b1;
        res.pos   = 3'(b);
      end
    end
    return res;
  endfunction

endpackage

/* rtl/bba_ram.sv */
// generic simple dual port ram with registered read
module bba_ram #(
  parameter int Width = 8,
  parameter int Depth = 2048,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered output
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bba_ceil_div.sv */
// ceiling divider of the inode count by a constant divisor, by reciprocal multiplication
module bba_ceil_div #(
  parameter int Divisor = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bba_pkg::InodeW-1:0] dividend_i,
  output logic [bba_pkg::InodeW-1:0] quotient_o
);
  import bba_pkg::*;

  // numerator is dividend + divisor - 1, one bit wider than the dividend
  localparam int NumW   = InodeW + 1;
  localparam int Log2D  = $clog2(Divisor);
  localparam int Shift  = NumW + Log2D;
  localparam int Recip  = ((1 << Shift) + Divisor - 1) / Divisor;
  localparam int RecipW = NumW + 1;
  localparam int ProdW  = NumW + RecipW;

  logic [NumW-1:0]   num;
  logic [ProdW-1:0]  prod;
  logic [InodeW-1:0] quot_q, quot_d;

  // floor((x + d - 1) / d) is exact for every numerator below 2^NumW
  assign num  = NumW'(dividend_i) + NumW'(Divisor - 1);
  assign prod = ProdW'(num) * ProdW'(Recip);

  always_comb begin
    quot_d = quot_q;
    if (start_i) begin
      quot_d = InodeW'(prod >> Shift);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q <= '0;
    end else begin
      quot_q <= quot_d;
    end
  end

  assign quotient_o = quot_q;

endmodule

/* rtl/bitmap_block_allocator.sv */
// top level of the first fit bitmap block allocator
// The free map (MAX_MAP_BLOCKS * BLOCK_BYTES bytes, msb of a byte is the lowest
// block) lives in one ram with a single read and a single write port, and one
// request is handled at a time. After reset the map is swept to zero, one
// byte a cycle, with the input stalled; configuration writes are taken
// throughout. A write of inode_count loads the map base, ceil(inode_count /
// INODE_SLOTS_PER_BLOCK), by a reciprocal multiplication in the same cycle, so
// it never stalls the input. An allocate reads one map byte per cycle through
// the ram read port, examining up to the bytes of the map blocks in use; its
// result waits in a result register until the output register is free and is
// then loaded into it. A free in range reads the map byte and then writes it
// back; an out of range free, a preload or an unused opcode goes straight to
// the response. The next request is accepted in the cycle after the result is
// loaded. A finished result sits in an output register, so the next request
// can be accepted while it waits.
`include "bitmap_block_allocator_assert.svh"

module bitmap_block_allocator #(
  parameter int BLOCK_BYTES           = 512,
  parameter int MAX_MAP_BLOCKS        = 4,
  parameter int INODE_SLOTS_PER_BLOCK = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_index_i,
  input  logic [bba_pkg::InodeW-1:0]   cfg_data_i,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bba_pkg::OpcodeW-1:0]  opcode_i,
  input  logic [bba_pkg::BlockW-1:0]   block_number_i,
  input  logic [bba_pkg::ByteIdxW-1:0] map_byte_index_i,
  input  logic [bba_pkg::ByteW-1:0]    map_byte_value_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bba_pkg::StatusW-1:0]  status_o,
  output logic [bba_pkg::BlockW-1:0]   allocated_block_o
);
  import bba_pkg::*;

  localparam int MapDepth = MAX_MAP_BLOCKS * BLOCK_BYTES;
  localparam int AddrW    = (MapDepth > 1) ? $clog2(MapDepth) : 1;
  localparam int CntW     = AddrW + 1;
  localparam int NblkW    = $clog2(MAX_MAP_BLOCKS + 1);
  localparam int FirstW   = ((NblkW > InodeW) ? NblkW : InodeW) + 1;

  // configuration registers
  logic [InodeW-1:0]  inode_count_q;
  logic [MapCntW-1:0] map_cnt_q;

  // control and payload registers
  state_e            state_q, state_d;
  logic [AddrW-1:0]  clr_addr_q, clr_addr_d;
  logic [CntW-1:0]   rd_addr_q, rd_addr_d;
  logic              chk_v_q, chk_v_d;
  logic [AddrW-1:0]  chk_addr_q, chk_addr_d;
  logic [AddrW-1:0]  free_addr_q, free_addr_d;
  logic [2:0]        free_bit_q, free_bit_d;
  status_e           res_status_q, res_status_d;
  logic [BlockW-1:0] res_block_q, res_block_d;
  logic              out_valid_q, out_valid_d;
  logic [StatusW-1:0] out_status_q, out_status_d;
  logic [BlockW-1:0] out_block_q, out_block_d;

  // ram ports
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [ByteW-1:0] ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [ByteW-1:0] ram_rdata;

  // derived values
  logic              div_start;
  logic [InodeW-1:0] map_base;
  logic [NblkW-1:0]  nblk;
  logic [CntW-1:0]   nbytes;
  logic [FirstW-1:0] first;
  logic              in_acc;
  logic              rd_issue;
  clear_pos_t        scan_pos;
  logic              scan_hit;
  logic [31:0]       blk_w;
  logic [31:0]       first_w;
  logic [31:0]       diff_w;
  logic              free_oor;
  logic              preload_ok;
  logic              slot_free;

  // configuration registers, ready at all times
  assign cfg_ready_o = 1'b1;
  assign div_start   = cfg_valid_i && cfg_ready_o && (cfg_index_i == CfgInodeCount);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inode_count_q <= '0;
      map_cnt_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgInodeCount) begin
        inode_count_q <= cfg_data_i;
      end else if (cfg_index_i == CfgMapBlocks) begin
        map_cnt_q <= cfg_data_i[MapCntW-1:0];
      end
    end
  end

  // map base = ceil(inode_count / INODE_SLOTS_PER_BLOCK)
  bba_ceil_div #(
    .Divisor (INODE_SLOTS_PER_BLOCK)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cfg_data_i),
    .quotient_o (map_base)
  );

  // map blocks in use, saturated at the store size
  always_comb begin
    if (32'(map_cnt_q) > 32'(MAX_MAP_BLOCKS)) begin
      nblk = NblkW'(MAX_MAP_BLOCKS);
    end else begin
      nblk = NblkW'(map_cnt_q);
    end
  end

  assign nbytes = CntW'(32'(nblk) * 32'(BLOCK_BYTES));
  assign first  = FirstW'(map_base) + FirstW'(nblk);

  // handshakes
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != SIdle);
  assign slot_free  = !out_valid_q || !out_stall_i;

  // scan of the map, one byte read per cycle
  assign rd_issue = (state_q == SScan) && (rd_addr_q < nbytes);
  assign scan_pos = first_clear(ram_rdata);
  assign scan_hit = (state_q == SScan) && chk_v_q && scan_pos.found;

  // free range check and bit position
  assign blk_w    = 32'(block_number_i);
  assign first_w  = 32'(first);
  assign diff_w   = blk_w - first_w;
  assign free_oor = (blk_w < first_w) || (diff_w >= (32'(nbytes) << 3));

  assign preload_ok = 32'(map_byte_index_i) < 32'(MapDepth);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SClear: begin
        if (clr_addr_q == AddrW'(MapDepth - 1)) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (in_acc) begin
          case (opcode_i)
            OpAlloc: state_d = SScan;
            OpFree:  state_d = free_oor ? SResp : SFreeWr;
            default: state_d = SResp;
          endcase
        end
      end
      SScan: begin
        if (scan_hit || !rd_issue) begin
          state_d = SResp;
        end
      end
      SFreeWr: state_d = SResp;
      SResp: begin
        if (slot_free) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // ram control and datapath
  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    clr_addr_d   = clr_addr_q;
    rd_addr_d    = rd_addr_q;
    chk_v_d      = chk_v_q;
    chk_addr_d   = chk_addr_q;
    free_addr_d  = free_addr_q;
    free_bit_d   = free_bit_q;
    res_status_d = res_status_q;
    res_block_d  = res_block_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_block_d  = out_block_q;

    // result taken downstream
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      // clearing sweep after reset
      SClear: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        clr_addr_d = clr_addr_q + 1'b1;
      end
      SIdle: begin
        if (in_acc) begin
          res_status_d = StOk;
          res_block_d  = '0;
          case (opcode_i)
            OpAlloc: begin
              rd_addr_d = '0;
              chk_v_d   = 1'b0;
            end
            OpFree: begin
              if (free_oor) begin
                res_status_d = StRange;
              end else begin
                ram_re      = 1'b1;
                ram_raddr   = AddrW'(diff_w >> 3);
                free_addr_d = AddrW'(diff_w >> 3);
                free_bit_d  = diff_w[2:0];
              end
            end
            OpPreload: begin
              if (preload_ok) begin
                ram_we    = 1'b1;
                ram_waddr = AddrW'(map_byte_index_i);
                ram_wdata = map_byte_value_i;
              end
            end
            default: ;
          endcase
        end
      end
      // read ahead one byte while checking the previous one
      SScan: begin
        ram_re     = rd_issue;
        ram_raddr  = rd_addr_q[AddrW-1:0];
        chk_v_d    = rd_issue;
        chk_addr_d = rd_addr_q[AddrW-1:0];
        if (rd_issue) begin
          rd_addr_d = rd_addr_q + 1'b1;
        end
        if (scan_hit) begin
          ram_we       = 1'b1;
          ram_waddr    = chk_addr_q;
          ram_wdata    = ram_rdata | (ByteMsb >> scan_pos.pos);
          res_status_d = StOk;
          res_block_d  = BlockW'(first_w + 32'({chk_addr_q, scan_pos.pos}));
        end else if (!rd_issue) begin
          res_status_d = StNoSpace;
          res_block_d  = '0;
        end
      end
      // clear the freed bit
      SFreeWr: begin
        ram_we    = 1'b1;
        ram_waddr = free_addr_q;
        ram_wdata = ram_rdata & (ByteAll ^ (ByteMsb >> free_bit_q));
      end
      SResp: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_block_d  = res_block_q;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      clr_addr_q  <= '0;
      chk_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      chk_v_q     <= chk_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_addr_q    <= rd_addr_d;
    chk_addr_q   <= chk_addr_d;
    free_addr_q  <= free_addr_d;
    free_bit_q   <= free_bit_d;
    res_status_q <= res_status_d;
    res_block_q  <= res_block_d;
    out_status_q <= out_status_d;
    out_block_q  <= out_block_d;
  end

  // free map store
  bba_ram #(
    .Width (ByteW),
    .Depth (MapDepth)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign allocated_block_o = out_block_q;

  // a scan never writes the byte it is reading ahead
  `BBA_ASSERT_NOW(a_no_rw_collide, ram_we && ram_re, ram_waddr != ram_raddr)
  // a granted byte always lies inside the map blocks in use
  `BBA_ASSERT_NOW(a_hit_in_map, scan_hit, CntW'(chk_addr_q) < nbytes)
  // a pending result waits while the output register is held
  `BBA_ASSERT_NEXT(a_resp_hold, (state_q == SResp) && out_valid_q && out_stall_i,
                   state_q == SResp)

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for the first fit bitmap block allocator
module tb;
  import bba_pkg::*;

  localparam int BlockBytes     = 512;
  localparam int MaxMapBlocks   = 4;
  localparam int InodesPerBlock = 8;
  localparam int MapBytes       = BlockBytes * MaxMapBlocks;
  localparam logic [OpcodeW-1:0] OpUnused = 2'd3;
  localparam int PrintCap = 40;

  typedef struct packed {
    logic [OpcodeW-1:0]  op;
    logic [BlockW-1:0]   block;
    logic [ByteIdxW-1:0] byte_idx;
    logic [ByteW-1:0]    byte_val;
  } request_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [BlockW-1:0]  block;
  } outcome_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_index_i = 1'b0;
  logic [InodeW-1:0]   cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [OpcodeW-1:0]  opcode_i = '0;
  logic [BlockW-1:0]   block_number_i = '0;
  logic [ByteIdxW-1:0] map_byte_index_i = '0;
  logic [ByteW-1:0]    map_byte_value_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [StatusW-1:0]  status_o;
  logic [BlockW-1:0]   allocated_block_o;

  // shadow free map and register copies
  bit   [ByteW-1:0]   map_shadow [MapBytes];
  logic [InodeW-1:0]  inode_cfg = '0;
  logic [MapCntW-1:0] map_blocks_cfg = '0;

  request_t    requests_pending [$];
  outcome_t    outcomes_due [$];
  request_t    on_wire;
  outcome_t    want;
  int unsigned requests_queued = 0;
  int unsigned outcomes_seen = 0;
  int unsigned mismatches = 0;
  int unsigned send_pause = 0;
  int unsigned hold_left = 0;
  int unsigned hold_len = 0;
  bit          steady = 1'b0;

  bitmap_block_allocator #(
    .BLOCK_BYTES          (BlockBytes),
    .MAX_MAP_BLOCKS       (MaxMapBlocks),
    .INODE_SLOTS_PER_BLOCK(InodesPerBlock)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .block_number_i   (block_number_i),
    .map_byte_index_i (map_byte_index_i),
    .map_byte_value_i (map_byte_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .allocated_block_o(allocated_block_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // map blocks in use, saturated at the store size
  function automatic int unsigned blocks_in_use();
    return (map_blocks_cfg > MaxMapBlocks) ? MaxMapBlocks : int'(map_blocks_cfg);
  endfunction

  // map base rounded up, plus the map blocks themselves
  function automatic int unsigned first_data_block();
    return (int'(inode_cfg) + InodesPerBlock - 1) / InodesPerBlock + blocks_in_use();
  endfunction

  // applies one request to the shadow map and gives the outcome it causes
  function automatic outcome_t apply_request(input request_t rq);
    outcome_t    res;
    int unsigned nbits;
    int unsigned first;
    int unsigned pos;
    bit          hit;
    res.status = StOk;
    res.block  = '0;
    nbits = blocks_in_use() * BlockBytes * 8;
    first = first_data_block();
    hit   = 1'b0;
    case (rq.op)
      OpAlloc: begin
        // first clear bit, msb of a byte is the lowest block
        res.status = StNoSpace;
        for (pos = 0; pos < nbits && !hit; pos++) begin
          if (!map_shadow[pos / 8][7 - pos % 8]) begin
            map_shadow[pos / 8][7 - pos % 8] = 1'b1;
            res.status = StOk;
            res.block  = BlockW'(first + pos);
            hit = 1'b1;
          end
        end
      end
      OpFree: begin
        if (rq.block < first || rq.block - first >= nbits) begin
          res.status = StRange;
        end else begin
          pos = rq.block - first;
          map_shadow[pos / 8][7 - pos % 8] = 1'b0;
        end
      end
      OpPreload: begin
        if (rq.byte_idx < MapBytes) map_shadow[rq.byte_idx] = rq.byte_val;
      end
      default: ;
    endcase
    return res;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [BlockW-1:0] got,
                                 input logic [BlockW-1:0] exp_val);
    if (mismatches < PrintCap)
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, exp_val);
    mismatches++;
  endtask

  // request driver, fed from the pending queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_pause <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) outcomes_due.push_back(apply_request(on_wire));
      if (!in_valid_i || !in_stall_o) begin
        if (send_pause != 0) begin
          in_valid_i <= 1'b0;
          send_pause <= send_pause - 1;
        end else if (requests_pending.size() != 0) begin
          on_wire = requests_pending.pop_front();
          opcode_i         <= on_wire.op;
          block_number_i   <= on_wire.block;
          map_byte_index_i <= on_wire.byte_idx;
          map_byte_value_i <= on_wire.byte_val;
          in_valid_i       <= 1'b1;
          send_pause       <= pick_pause();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        outcomes_seen++;
        if (outcomes_due.size() == 0) begin
          report_mismatch("result with none due", allocated_block_o, '0);
        end else begin
          want = outcomes_due.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", BlockW'(status_o), BlockW'(want.status));
          if (allocated_block_o !== want.block)
            report_mismatch("allocated block", allocated_block_o, want.block);
        end
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if ((out_valid_o && !out_stall_i) || $urandom_range(0, 19) == 0) begin
        hold_len = pick_pause();
        out_stall_i <= (hold_len != 0);
        hold_left   <= (hold_len != 0) ? hold_len - 1 : 0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic queue_request(input logic [OpcodeW-1:0] op, input logic [BlockW-1:0] blk,
                               input logic [ByteIdxW-1:0] idx, input logic [ByteW-1:0] val);
    request_t rq;
    rq.op       = op;
    rq.block    = blk;
    rq.byte_idx = idx;
    rq.byte_val = val;
    requests_pending.push_back(rq);
    requests_queued++;
  endtask

  task automatic wait_for_results();
    while (outcomes_seen != requests_queued) @(posedge clk_i);
  endtask

  // one transfer on the register write channel
  task automatic write_reg(input logic idx, input logic [InodeW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CfgInodeCount) inode_cfg = data;
    else map_blocks_cfg = data[MapCntW-1:0];
  endtask

  task automatic set_config(input int unsigned inode, input int unsigned cnt);
    wait_for_results();
    write_reg(CfgInodeCount, InodeW'(inode));
    write_reg(CfgMapBlocks, InodeW'(cnt));
  endtask

  // random mix, frees aimed mostly at the low end of the map where grants land
  task automatic queue_random(input int unsigned n, input int unsigned alloc_pct);
    int unsigned j;
    int unsigned r;
    int unsigned nbits;
    int unsigned first;
    request_t    rq;
    nbits = blocks_in_use() * BlockBytes * 8;
    first = first_data_block();
    for (j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      rq.op       = OpAlloc;
      rq.block    = BlockW'($urandom);
      rq.byte_idx = ByteIdxW'($urandom);
      rq.byte_val = ByteW'($urandom);
      if (r >= alloc_pct && r < alloc_pct + 30) begin
        rq.op = OpFree;
        r = $urandom_range(0, 9);
        if (nbits != 0 && r < 7) rq.block = BlockW'(first + $urandom_range(0, 63));
        else if (nbits != 0 && r == 7) rq.block = BlockW'(first + nbits - 1 + $urandom_range(0, 1));
        else if (r == 8 && first != 0) rq.block = BlockW'($urandom_range(0, first - 1));
      end else if (r >= alloc_pct + 30 && r < alloc_pct + 45) begin
        rq.op = OpPreload;
        if ($urandom_range(0, 3) != 0) rq.byte_idx = ByteIdxW'($urandom_range(0, 15));
        if ($urandom_range(0, 2) == 0) rq.byte_val = ByteAll;
      end else if (r >= alloc_pct + 45 && r < alloc_pct + 50) begin
        rq.op = OpUnused;
      end
      queue_request(rq.op, rq.block, rq.byte_idx, rq.byte_val);
    end
  endtask

  // stimulus
  initial begin
    int unsigned k;
    int unsigned i;
    int unsigned sel;
    int unsigned inode;
    int unsigned hole;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration: no map block in use
    queue_request(OpAlloc, '0, '0, '0);
    queue_request(OpFree, '0, '0, '0);
    queue_request(OpPreload, '0, '0, ByteAll);
    queue_request(OpPreload, '1, '1, '0);
    queue_request(OpUnused, '1, '1, '1);

    // largest inode count and full map: data blocks start at 516
    steady = 1'b1;
    set_config(4095, MaxMapBlocks);
    queue_request(OpAlloc, '0, '0, '0);
    queue_request(OpAlloc, '0, '0, '0);
    queue_request(OpFree, 16'd517, '0, '0);
    queue_request(OpFree, 16'd517, '0, '0);
    queue_request(OpAlloc, '0, '0, '0);
    queue_request(OpFree, 16'd515, '0, '0);
    queue_request(OpFree, 16'd16900, '0, '0);
    queue_request(OpFree, 16'd16899, '0, '0);
    queue_request(OpFree, '1, '0, '0);
    queue_request(OpPreload, '0, 11'd0, ByteAll);
    queue_request(OpPreload, '0, 11'd1, 8'h7F);
    queue_request(OpAlloc, '0, '0, '0);
    queue_request(OpPreload, '0, 11'd0, 8'hFE);
    queue_request(OpAlloc, '0, '0, '0);
    queue_request(OpPreload, '0, '1, ByteAll);
    queue_request(OpUnused, BlockW'($urandom), ByteIdxW'($urandom), ByteW'($urandom));

    // map count above the maximum saturates
    steady = 1'b0;
    set_config(1, 7);
    queue_request(OpAlloc, '0, '0, '0);
    queue_request(OpFree, 16'd5, '0, '0);
    queue_request(OpAlloc, '0, '0, '0);

    // random phases, one of them filling a single map block to exhaustion
    for (k = 0; k < 7; k++) begin
      steady = (k == 1);
      sel = $urandom_range(0, 3);
      inode = (sel == 0) ? 0 : (sel == 1) ? 4095 : $urandom_range(0, 4095);
      if (k == 3) begin
        set_config(inode, 1);
        hole = $urandom_range(0, BlockBytes - 1);
        for (i = 0; i < BlockBytes; i++)
          queue_request(OpPreload, BlockW'($urandom), ByteIdxW'(i),
                        (i == hole) ? ByteW'($urandom) : ByteAll);
        repeat (20) queue_request(OpAlloc, BlockW'($urandom), ByteIdxW'($urandom), ByteW'($urandom));
        queue_random(40, 60);
      end else begin
        set_config(inode, (k == 0) ? 5 : $urandom_range(0, 7));
        queue_random(42, 45);
      end
    end

    // drain, then let the block settle
    wait_for_results();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && outcomes_due.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #50_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
